// ----- rtl/contact_velocity_response_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for contact_velocity_response
// Concurrent checks on the block's own logic. Define NO_ASSERTIONS to drop them.
// ---------------------------------------------------------------------------
`ifndef CONTACT_VELOCITY_RESPONSE_MACROS_SVH
`define CONTACT_VELOCITY_RESPONSE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define CVR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("contact_velocity_response: assertion failed");

// next-cycle implication
`define CVR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("contact_velocity_response: assertion failed");

`else

`define CVR_ASSERT_IMPLY(label, clk, rst, ante, cons)

`define CVR_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/cvr_pkg.sv -----
// ---------------------------------------------------------------------------
// cvr_pkg
// Types and constants shared by the contact velocity response block.
// ---------------------------------------------------------------------------
package cvr_pkg;

   // config register indexes
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INVERSE_MASS = 3'd0,
      CSR_FORCE_X      = 3'd1,
      CSR_FORCE_Y      = 3'd2,
      CSR_FORCE_Z      = 3'd3,
      CSR_RESTITUTION  = 3'd4,
      CSR_FRICTION     = 3'd5,
      CSR_STOP_THR     = 3'd6,
      CSR_SLIP_THR     = 3'd7
   } csr_index_type;

   // register reset values
   localparam logic [15:0] RESTITUTION_RST = 16'd29491;
   localparam logic [15:0] FRICTION_RST    = 16'd29491;
   localparam logic [31:0] STOP_THR_RST    = 32'd429497;
   localparam logic [31:0] SLIP_THR_RST    = 32'd43;

   // sequencer states
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DOT,
      ST_NN,
      ST_DIV1_START,
      ST_DIV1_WAIT,
      ST_MULQ,
      ST_MULR,
      ST_DIV2_START,
      ST_DIV2_WAIT,
      ST_VD,
      ST_SMALL_N,
      ST_SCALE_N,
      ST_SMALL_D,
      ST_SCALE_D,
      ST_ACC,
      ST_LOAD,
      ST_FORCE,
      ST_SMALL_V,
      ST_OUT
   } state_type;

endpackage

// ----- rtl/cvr_div.sv -----
// ---------------------------------------------------------------------------
// cvr_div
// Restoring divider, one quotient bit per cycle, 32-bit divisor. The
// dividend shifts out of the top of a register while quotient bits enter
// at the bottom; a partial remainder may be preloaded.
// ---------------------------------------------------------------------------
module cvr_div #(
   parameter int DW = 48
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [$clog2(DW+1)-1:0]     steps,
   input  logic [31:0]                 divisor,
   input  logic [31:0]                 rem_init,
   input  logic [DW-1:0]               dvd_init,
   output logic                        done,
   output logic [DW-1:0]               quot,
   output logic [31:0]                 rem
);

   localparam int SCW = $clog2(DW+1);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [SCW-1:0]  cnt_ff, cnt_in;
   logic [31:0]     rem_ff, rem_in;
   logic [DW-1:0]   shr_ff, shr_in;
   logic [32:0]     trial;
   logic            ge;

   // one restoring step
   assign trial = {rem_ff, shr_ff[DW-1]};
   assign ge    = (trial >= {1'b0, divisor});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      shr_in  = shr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = steps;
         rem_in  = rem_init;
         shr_in  = dvd_init;
      end else if (busy_ff) begin
         rem_in = ge ? 32'(trial - {1'b0, divisor}) : trial[31:0];
         shr_in = {shr_ff[DW-2:0], ge};
         cnt_in = cnt_ff - SCW'(1);
         if (cnt_ff == SCW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      shr_ff <= shr_in;
   end

   assign done = done_ff;
   assign quot = shr_ff;
   assign rem  = rem_ff;

endmodule

// ----- rtl/contact_velocity_response.sv -----
// ---------------------------------------------------------------------------
// contact_velocity_response
// Keeps a body velocity; each contact beat splits it into normal and
// tangential parts, applies restitution and friction and sums the results.
// The last beat of an update loads the sum, adds force times inverse mass
// and returns the velocity and orientation.
//
// Channels: req_ (contact beats), rsp_ (one result per last beat), csr_
// (register writes, always ready; the user must write only while the block
// is idle, which the block itself does not enforce). A contact beat with a
// nonzero normal runs four serial divisions in the shared divider (one
// full-width, three of 16 bits) plus passes of the shared multiplier over
// the three components. A beat with neither contact nor last flag is
// absorbed without leaving idle. req_ready is high only while idle.
// The result sits in an output register; the next beat is accepted while
// it waits. If the receiver stalls, the following result holds in the
// sequencer until the register is free.
// Reset zeroes velocity and sums and loads register defaults.
// ---------------------------------------------------------------------------
module contact_velocity_response #(
   parameter int VELOCITY_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [15:0]              req_normal_x,
   input  logic signed [15:0]              req_normal_y,
   input  logic signed [15:0]              req_normal_z,
   input  logic                            req_has_contact,
   input  logic                            req_last_contact,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [31:0]              rsp_vel_out_x,
   output logic signed [31:0]              rsp_vel_out_y,
   output logic signed [31:0]              rsp_vel_out_z,
   output logic signed [31:0]              rsp_spin_x,
   output logic signed [31:0]              rsp_spin_z,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cvr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [31:0]                     csr_data
);

   import cvr_pkg::*;
   `include "contact_velocity_response_macros.svh"

   localparam int V   = VELOCITY_WIDTH;
   localparam int SW  = V + 4;                  // running sums
   localparam int EW  = V + 4;                  // normal / tangential parts
   localparam int MW  = V + 16;                 // |dot| and quotient
   localparam int DTW = V + 18;                 // signed dot product
   localparam int AW  = MW;                     // multiplier operand A
   localparam int BW  = 24;                     // multiplier operand B
   localparam int PW  = AW + BW;
   localparam int SPW = (EW + 16 > 64) ? 64 : EW + 16;
   localparam int XW  = ((V > 40) ? V : 40) + 2;
   localparam int SCW = $clog2(MW + 1);

   // sequencer
   state_type state_ff, state_in;
   logic [1:0] cnt_ff, cnt_in;
   logic [1:0] idx_ff;
   logic [1:0] mi, wi, ni, vi;

   // configuration
   logic [23:0]         inv_mass_ff;
   logic signed [31:0]  force_ff [3];
   logic [15:0]         rest_ff, fric_ff;
   logic [31:0]         stop_thr_ff, slip_thr_ff;

   // architectural state
   logic signed [V-1:0]  vel_ff [3];
   logic signed [SW-1:0] sum_ff [3];
   logic                 saw_ff;

   // per-contact work registers
   logic signed [15:0]   n_ff [3];
   logic                 last_ff;
   logic signed [DTW-1:0] dot_ff;
   logic [31:0]          nn_ff;
   logic [MW-1:0]        q_ff;
   logic [31:0]          r_ff;
   logic [EW-1:0]        vnmag_ff;
   logic signed [EW-1:0] vn_ff [3];
   logic signed [EW-1:0] vd_ff [3];
   logic [PW-1:0]        prod_ff;
   logic                 prod_neg_ff;
   logic [33:0]          sq_acc_ff;
   logic                 big_ff, small_ff;

   // output register
   logic                 rsp_valid_ff;
   logic signed [31:0]   vel_out_ff [3];
   logic signed [31:0]   spin_x_ff, spin_z_ff;

   // shared multiplier
   logic [AW-1:0]        mul_a;
   logic [BW-1:0]        mul_b;
   logic                 mul_neg;
   logic [PW-1:0]        mul_p;

   // operand selection
   logic signed [15:0]   n_sel;
   logic [15:0]          nmag;
   logic signed [V-1:0]  vel_sel;
   logic [V-1:0]         vmag;
   logic signed [EW-1:0] csel;
   logic [EW-1:0]        cmag;
   logic                 cmag_big;
   logic signed [31:0]   fsel;
   logic [31:0]          fmag;

   // divider hookup
   logic                 div_start, div_done;
   logic [SCW-1:0]       div_steps;
   logic [31:0]          div_rem_init, div_rem;
   logic [MW-1:0]        div_dvd_init, div_quot;

   // datapath helpers
   logic signed [DTW-1:0] dot_term;
   logic [DTW-1:0]       dot_mag;
   logic [EW-1:0]        vn_mag_sum;
   logic                 vn_neg;
   logic [EW-1:0]        sc_mag;
   logic [33:0]          sq_next;
   logic [31:0]          thr_sel;
   logic signed [56:0]   fprod;
   logic signed [56:0]   fshift;
   logic signed [XW-1:0] vel_push;
   logic signed [V:0]    vx_ext, vz_ext, half_x_neg, half_z;
   logic                 out_free;

   // -----------------------------------------------------------------------
   // saturation helpers
   // -----------------------------------------------------------------------
   function automatic logic signed [SW-1:0] sat_sum(input logic signed [SW+1:0] x);
      logic fits;
      fits = (&x[SW+1:SW-1]) || !(|x[SW+1:SW-1]);
      if (fits) return x[SW-1:0];
      else if (x[SW+1]) return {1'b1, {(SW-1){1'b0}}};
      else return {1'b0, {(SW-1){1'b1}}};
   endfunction

   function automatic logic signed [V-1:0] sat_vel_sum(input logic signed [SW-1:0] x);
      logic fits;
      fits = (&x[SW-1:V-1]) || !(|x[SW-1:V-1]);
      if (fits) return x[V-1:0];
      else if (x[SW-1]) return {1'b1, {(V-1){1'b0}}};
      else return {1'b0, {(V-1){1'b1}}};
   endfunction

   function automatic logic signed [V-1:0] sat_vel(input logic signed [XW-1:0] x);
      logic fits;
      fits = (&x[XW-1:V-1]) || !(|x[XW-1:V-1]);
      if (fits) return x[V-1:0];
      else if (x[XW-1]) return {1'b1, {(V-1){1'b0}}};
      else return {1'b0, {(V-1){1'b1}}};
   endfunction

   // -----------------------------------------------------------------------
   // operand read ports: one index per array
   // -----------------------------------------------------------------------
   assign mi = (cnt_ff == 2'd3) ? 2'd2 : cnt_ff;
   assign wi = cnt_ff - 2'd1;
   assign ni = (state_ff inside {ST_MULQ, ST_MULR, ST_DIV2_START, ST_DIV2_WAIT}) ? idx_ff : mi;
   assign vi = (state_ff == ST_FORCE) ? wi : mi;

   assign n_sel   = n_ff[ni];
   assign nmag    = n_sel[15] ? 16'(-n_sel) : 16'(n_sel);
   assign vel_sel = vel_ff[vi];
   assign vmag    = vel_sel[V-1] ? V'(-vel_sel) : V'(vel_sel);
   assign fsel    = force_ff[mi];
   assign fmag    = fsel[31] ? 32'(-fsel) : 32'(fsel);

   always_comb begin
      csel = EW'(vel_sel);
      if (state_ff inside {ST_SMALL_N, ST_SCALE_N}) begin
         csel = vn_ff[mi];
      end else if (state_ff inside {ST_SMALL_D, ST_SCALE_D}) begin
         csel = vd_ff[mi];
      end
   end

   assign cmag     = csel[EW-1] ? EW'(-csel) : EW'(csel);
   assign cmag_big = |cmag[EW-1:16];

   // -----------------------------------------------------------------------
   // shared multiplier, result registered in prod_ff
   // -----------------------------------------------------------------------
   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      mul_neg = 1'b0;
      case (state_ff)
         ST_DOT: begin
            mul_a   = AW'(vmag);
            mul_b   = BW'(nmag);
            mul_neg = vel_sel[V-1] ^ n_sel[15];
         end
         ST_NN: begin
            mul_a = AW'(nmag);
            mul_b = BW'(nmag);
         end
         ST_MULQ: begin
            mul_a = q_ff;
            mul_b = BW'(nmag);
         end
         ST_MULR: begin
            mul_a = AW'(r_ff);
            mul_b = BW'(nmag);
         end
         ST_SMALL_N, ST_SMALL_D, ST_SMALL_V: begin
            mul_a = AW'(cmag[15:0]);
            mul_b = BW'(cmag[15:0]);
         end
         ST_SCALE_N: begin
            mul_a   = AW'(cmag);
            mul_b   = BW'(rest_ff);
            mul_neg = csel[EW-1];
         end
         ST_SCALE_D: begin
            mul_a   = AW'(cmag);
            mul_b   = BW'(fric_ff);
            mul_neg = csel[EW-1];
         end
         ST_FORCE: begin
            mul_a   = AW'(fmag);
            mul_b   = inv_mass_ff;
            mul_neg = fsel[31];
         end
         default: ;
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // -----------------------------------------------------------------------
   // divider
   // -----------------------------------------------------------------------
   assign dot_mag      = dot_ff[DTW-1] ? DTW'(-dot_ff) : DTW'(dot_ff);
   assign div_start    = (state_ff == ST_DIV1_START && nn_ff != 32'd0) ||
                         (state_ff == ST_DIV2_START);
   assign div_steps    = (state_ff == ST_DIV2_START) ? SCW'(16) : SCW'(MW);
   assign div_rem_init = (state_ff == ST_DIV2_START) ? prod_ff[47:16] : 32'd0;
   assign div_dvd_init = (state_ff == ST_DIV2_START) ?
                         {prod_ff[15:0], {(MW-16){1'b0}}} : MW'(dot_mag);

   cvr_div #(
      .DW (MW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .steps    (div_steps),
      .divisor  (nn_ff),
      .rem_init (div_rem_init),
      .dvd_init (div_dvd_init),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   // -----------------------------------------------------------------------
   // datapath helpers
   // -----------------------------------------------------------------------
   always_comb begin
      dot_term = DTW'(prod_ff);
      if (prod_neg_ff) dot_term = -dot_term;
   end

   assign vn_mag_sum = vnmag_ff + EW'(div_quot[15:0]);
   assign vn_neg     = dot_ff[DTW-1] ^ n_sel[15];
   assign sc_mag     = EW'(prod_ff[SPW-1:15]);
   assign sq_next    = sq_acc_ff + 34'(prod_ff[31:0]);
   assign thr_sel    = (state_ff == ST_SMALL_D) ? slip_thr_ff : stop_thr_ff;

   // force term, floor shift by 16
   always_comb begin
      fprod = $signed({2'b00, prod_ff[54:0]});
      if (prod_neg_ff) fprod = -fprod;
   end
   assign fshift   = fprod >>> 16;
   assign vel_push = XW'(vel_sel) + XW'(fshift);

   // orientation halves
   assign vx_ext     = {vel_ff[0][V-1], vel_ff[0]};
   assign vz_ext     = {vel_ff[2][V-1], vel_ff[2]};
   assign half_x_neg = -(vx_ext >>> 1);
   assign half_z     = vz_ext >>> 1;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // -----------------------------------------------------------------------
   // sequencer
   // -----------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = 2'd0;
            if (req_valid) begin
               if (req_has_contact) state_in = ST_DOT;
               else if (req_last_contact) state_in = ST_LOAD;
            end
         end
         ST_DOT, ST_NN, ST_SMALL_N, ST_SCALE_N, ST_SMALL_D, ST_SCALE_D,
         ST_FORCE, ST_SMALL_V: begin
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               cnt_in = 2'd0;
               case (state_ff)
                  ST_DOT:     state_in = ST_NN;
                  ST_NN:      state_in = ST_DIV1_START;
                  ST_SMALL_N: state_in = ST_SCALE_N;
                  ST_SCALE_N: state_in = ST_SMALL_D;
                  ST_SMALL_D: state_in = ST_SCALE_D;
                  ST_SCALE_D: state_in = ST_ACC;
                  ST_FORCE:   state_in = ST_SMALL_V;
                  default:    state_in = ST_OUT;
               endcase
            end
         end
         ST_DIV1_START: state_in = (nn_ff == 32'd0) ? ST_VD : ST_DIV1_WAIT;
         ST_DIV1_WAIT:  if (div_done) state_in = ST_MULQ;
         ST_MULQ:       state_in = ST_MULR;
         ST_MULR:       state_in = ST_DIV2_START;
         ST_DIV2_START: state_in = ST_DIV2_WAIT;
         ST_DIV2_WAIT: begin
            if (div_done) state_in = (idx_ff == 2'd2) ? ST_VD : ST_MULQ;
         end
         ST_VD:   state_in = ST_SMALL_N;
         ST_ACC:  state_in = last_ff ? ST_LOAD : ST_IDLE;
         ST_LOAD: state_in = ST_FORCE;
         ST_OUT:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // -----------------------------------------------------------------------
   // registers: config, state, work and output
   // -----------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         inv_mass_ff  <= '0;
         force_ff     <= '{default: '0};
         rest_ff      <= RESTITUTION_RST;
         fric_ff      <= FRICTION_RST;
         stop_thr_ff  <= STOP_THR_RST;
         slip_thr_ff  <= SLIP_THR_RST;
         vel_ff       <= '{default: '0};
         sum_ff       <= '{default: '0};
         saw_ff       <= 1'b0;
         sq_acc_ff    <= '0;
         big_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // register writes
         if (csr_valid) begin
            case (csr_index)
               CSR_INVERSE_MASS: inv_mass_ff <= csr_data[23:0];
               CSR_FORCE_X:      force_ff[0] <= csr_data;
               CSR_FORCE_Y:      force_ff[1] <= csr_data;
               CSR_FORCE_Z:      force_ff[2] <= csr_data;
               CSR_RESTITUTION:  rest_ff     <= csr_data[15:0];
               CSR_FRICTION:     fric_ff     <= csr_data[15:0];
               CSR_STOP_THR:     stop_thr_ff <= csr_data;
               CSR_SLIP_THR:     slip_thr_ff <= csr_data;
               default: ;
            endcase
         end

         // drained result; a reload in ST_OUT takes over below
         if (rsp_valid_ff && rsp_ready && state_ff != ST_OUT) rsp_valid_ff <= 1'b0;

         prod_ff     <= mul_p;
         prod_neg_ff <= mul_neg;

         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  n_ff[0] <= req_normal_x;
                  n_ff[1] <= req_normal_y;
                  n_ff[2] <= req_normal_z;
                  last_ff <= req_last_contact;
                  dot_ff  <= '0;
                  nn_ff   <= '0;
               end
            end
            ST_DOT: if (cnt_ff != 2'd0) dot_ff <= dot_ff + dot_term;
            ST_NN:  if (cnt_ff != 2'd0) nn_ff <= nn_ff + prod_ff[31:0];
            ST_DIV1_START: begin
               idx_ff <= 2'd0;
               if (nn_ff == 32'd0) vn_ff <= '{default: '0};
            end
            ST_DIV1_WAIT: begin
               if (div_done) begin
                  q_ff <= div_quot;
                  r_ff <= div_rem;
               end
            end
            ST_MULR: vnmag_ff <= EW'(prod_ff);
            ST_DIV2_WAIT: begin
               if (div_done) begin
                  vn_ff[idx_ff] <= vn_neg ? -vn_mag_sum : vn_mag_sum;
                  idx_ff        <= idx_ff + 2'd1;
               end
            end
            ST_VD: begin
               for (int i = 0; i < 3; i++) begin
                  vd_ff[i] <= EW'(vel_ff[i]) - vn_ff[i];
               end
            end
            ST_SMALL_N, ST_SMALL_D, ST_SMALL_V: begin
               if (cnt_ff != 2'd3) big_ff <= big_ff | cmag_big;
               if (cnt_ff != 2'd0 && cnt_ff != 2'd3) sq_acc_ff <= sq_next;
               if (cnt_ff == 2'd3) begin
                  small_ff  <= !big_ff && (sq_next < {2'b00, thr_sel});
                  sq_acc_ff <= '0;
                  big_ff    <= 1'b0;
               end
            end
            ST_SCALE_N: begin
               if (cnt_ff != 2'd0) begin
                  vn_ff[wi] <= small_ff ? '0 : (prod_neg_ff ? sc_mag : -sc_mag);
               end
            end
            ST_SCALE_D: begin
               if (cnt_ff != 2'd0) begin
                  vd_ff[wi] <= small_ff ? '0 : (prod_neg_ff ? -sc_mag : sc_mag);
               end
            end
            ST_ACC: begin
               for (int i = 0; i < 3; i++) begin
                  sum_ff[i] <= sat_sum((SW+2)'(sum_ff[i]) + (SW+2)'(vn_ff[i]) +
                                       (SW+2)'(vd_ff[i]));
               end
               saw_ff <= 1'b1;
            end
            ST_LOAD: begin
               if (saw_ff) begin
                  for (int i = 0; i < 3; i++) begin
                     vel_ff[i] <= sat_vel_sum(sum_ff[i]);
                  end
               end
               sum_ff <= '{default: '0};
               saw_ff <= 1'b0;
            end
            ST_FORCE: if (cnt_ff != 2'd0) vel_ff[wi] <= sat_vel(vel_push);
            ST_OUT: begin
               if (out_free) begin
                  for (int i = 0; i < 3; i++) begin
                     vel_out_ff[i] <= 32'(vel_ff[i]);
                  end
                  spin_x_ff    <= small_ff ? 32'sd0 : 32'(half_z);
                  spin_z_ff    <= small_ff ? 32'sd0 : 32'(half_x_neg);
                  rsp_valid_ff <= 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // -----------------------------------------------------------------------
   // ports
   // -----------------------------------------------------------------------
   assign req_ready     = (state_ff == ST_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_vel_out_x = vel_out_ff[0];
   assign rsp_vel_out_y = vel_out_ff[1];
   assign rsp_vel_out_z = vel_out_ff[2];
   assign rsp_spin_x    = spin_x_ff;
   assign rsp_spin_z    = spin_z_ff;

   // -----------------------------------------------------------------------
   // assertions
   // -----------------------------------------------------------------------
   `CVR_ASSERT_IMPLY(a_sum_clear, clock, reset, !saw_ff, sum_ff[0] == '0 && sum_ff[1] == '0 && sum_ff[2] == '0)
   `CVR_ASSERT_IMPLY(a_div_done_waited, clock, reset, div_done, state_ff == ST_DIV1_WAIT || state_ff == ST_DIV2_WAIT)
   `CVR_ASSERT_NEXT(a_contact_starts, clock, reset, req_valid && req_ready && req_has_contact, state_ff == ST_DOT)
   `CVR_ASSERT_IMPLY(a_rsp_from_out, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_OUT)

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench for contact_velocity_response
// Sends contact beats and closing beats through the request channel. A
// bit-accurate fixed-point predictor of the velocity update runs beside the
// block, and every result beat is checked field by field against it. The
// run steps through several register settings, the extremes among them,
// under changing amounts of idling on both channels.
// ----------------------------------------------------------------------------
module tb;
   import cvr_pkg::*;

   localparam int VW         = 32;
   localparam int SW         = VW + 4;
   localparam int CYCLE_CAP  = 2000000;
   localparam int SETTLE     = 300;
   localparam int HOLD_LEN   = 600;
   localparam int PHASES     = 8;
   localparam int PHASE_BEATS = 190;

   typedef struct {
      logic signed [15:0] nx, ny, nz;
      logic               has, last;
   } contact_beat_type;

   typedef struct {
      logic [31:0] vx, vy, vz, sx, sz;
   } velocity_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [15:0] req_normal_x = '0, req_normal_y = '0, req_normal_z = '0;
   logic req_has_contact = 1'b0, req_last_contact = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_vel_out_x, rsp_vel_out_y, rsp_vel_out_z;
   logic signed [31:0] rsp_spin_x, rsp_spin_z;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   contact_beat_type    beat_q[$];
   velocity_result_type velocity_q[$];
   contact_beat_type    next_beat;

   int send_idle = 0, recv_idle = 0;
   int mismatches = 0;
   int cycles = 0;
   int hold_cnt = 0;
   logic hold_req = 1'b0, hold_seen = 1'b0;

   // predictor state and register copies
   longint          vel_m[3], sum_m[3];
   bit              saw_m;
   longint unsigned inv_mass_c, rest_c, fric_c, stop_c, slip_c;
   longint          force_c[3];

   contact_velocity_response u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // fixed-point helpers
   // ------------------------------------------------------------------------
   function automatic longint clamp_w(longint x, int w);
      longint hi;
      hi = (longint'(1) <<< (w - 1)) - 1;
      if (x > hi) return hi;
      if (x < -hi - 1) return -hi - 1;
      return x;
   endfunction

   function automatic longint unsigned mag(longint x);
      return (x < 0) ? longint'(-x) : x;
   endfunction

   function automatic longint signed_of(longint unsigned m, bit neg);
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic bit below_sq(longint c[3], longint unsigned thr);
      longint unsigned acc, a;
      acc = 0;
      for (int i = 0; i < 3; i++) begin
         a = mag(c[i]);
         if (a >= 64'd65536) return 1'b0;
         acc += a * a;
      end
      return acc < thr;
   endfunction

   function automatic longint coef_scale(longint x, longint unsigned coef);
      return signed_of((mag(x) * coef) >> 15, x < 0);
   endfunction

   // one contact: split, damp and accumulate
   task automatic add_contact(longint n[3]);
      longint v[3], vn[3], vd[3], p;
      longint unsigned pos, neg, nn, m, q, r, a;
      bit dneg;
      pos = 0; neg = 0; nn = 0;
      for (int i = 0; i < 3; i++) begin
         v[i] = vel_m[i];
         vn[i] = 0;
         p = n[i] * v[i];
         if (p >= 0) pos += p; else neg += mag(p);
         nn += longint'(n[i] * n[i]);
      end
      if (nn != 0) begin
         dneg = neg > pos;
         m = dneg ? neg - pos : pos - neg;
         q = m / nn;
         r = m % nn;
         for (int i = 0; i < 3; i++) begin
            a = mag(n[i]);
            vn[i] = signed_of(a * q + (a * r) / nn, dneg != (n[i] < 0));
         end
      end
      for (int i = 0; i < 3; i++) vd[i] = v[i] - vn[i];
      if (below_sq(vn, stop_c)) begin
         for (int i = 0; i < 3; i++) vn[i] = 0;
      end else begin
         for (int i = 0; i < 3; i++) vn[i] = -coef_scale(vn[i], rest_c);
      end
      if (below_sq(vd, slip_c)) begin
         for (int i = 0; i < 3; i++) vd[i] = 0;
      end else begin
         for (int i = 0; i < 3; i++) vd[i] = coef_scale(vd[i], fric_c);
      end
      for (int i = 0; i < 3; i++) sum_m[i] = clamp_w(sum_m[i] + vn[i] + vd[i], SW);
      saw_m = 1'b1;
   endtask

   // accepted request beat: update the predictor, queue a result on last
   task automatic predict_velocity(contact_beat_type b);
      longint n[3];
      velocity_result_type res;
      if (b.has) begin
         n[0] = b.nx; n[1] = b.ny; n[2] = b.nz;
         add_contact(n);
      end
      if (b.last) begin
         for (int i = 0; i < 3; i++) begin
            if (saw_m) vel_m[i] = clamp_w(sum_m[i], VW);
            sum_m[i] = 0;
            vel_m[i] = clamp_w(vel_m[i] + ((force_c[i] * longint'(inv_mass_c)) >>> 16), VW);
         end
         saw_m = 1'b0;
         res.vx = vel_m[0][31:0];
         res.vy = vel_m[1][31:0];
         res.vz = vel_m[2][31:0];
         if (below_sq(vel_m, stop_c)) begin
            res.sx = '0;
            res.sz = '0;
         end else begin
            res.sx = 32'(vel_m[2] >>> 1);
            res.sz = 32'(-(vel_m[0] >>> 1));
         end
         velocity_q.push_back(res);
      end
   endtask

   // ------------------------------------------------------------------------
   // request driver
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            predict_velocity('{req_normal_x, req_normal_y, req_normal_z,
                               req_has_contact, req_last_contact});
         if (!req_valid || req_ready) begin
            if (beat_q.size() > 0 && $urandom_range(99) >= send_idle) begin
               next_beat = beat_q.pop_front();
               req_valid        <= 1'b1;
               req_normal_x     <= next_beat.nx;
               req_normal_y     <= next_beat.ny;
               req_normal_z     <= next_beat.nz;
               req_has_contact  <= next_beat.has;
               req_last_contact <= next_beat.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, counted on its own
   always @(posedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_cnt  <= HOLD_LEN;
      end else if (hold_cnt != 0) begin
         hold_cnt <= hold_cnt - 1;
      end
   end

   // result ready
   always @(posedge clock) begin
      if (reset || hold_cnt != 0) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (velocity_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat at cycle %0d", cycles);
         end else begin
            velocity_result_type e;
            e = velocity_q.pop_front();
            if (rsp_vel_out_x !== e.vx || rsp_vel_out_y !== e.vy ||
                rsp_vel_out_z !== e.vz || rsp_spin_x !== e.sx || rsp_spin_z !== e.sz) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch cycle %0d: exp v=%h %h %h spin=%h %h got v=%h %h %h spin=%h %h",
                           cycles, e.vx, e.vy, e.vz, e.sx, e.sz, rsp_vel_out_x,
                           rsp_vel_out_y, rsp_vel_out_z, rsp_spin_x, rsp_spin_z);
            end
         end
      end
   end

   // cycle cap
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("tb failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   task automatic write_reg(csr_index_type idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_INVERSE_MASS: inv_mass_c = value[23:0];
         CSR_FORCE_X:      force_c[0] = longint'($signed(value));
         CSR_FORCE_Y:      force_c[1] = longint'($signed(value));
         CSR_FORCE_Z:      force_c[2] = longint'($signed(value));
         CSR_RESTITUTION:  rest_c = value[15:0];
         CSR_FRICTION:     fric_c = value[15:0];
         CSR_STOP_THR:     stop_c = value;
         CSR_SLIP_THR:     slip_c = value;
         default: ;
      endcase
   endtask

   function automatic logic [31:0] rand_force();
      return $signed($urandom) >>> $urandom_range(0, 24);
   endfunction

   function automatic logic signed [15:0] rand_comp(int kind);
      case (kind)
         0: return 16'sd0;
         1: return $urandom_range(1) ? 16'sd16384 : -16'sd16384;
         4: return $signed(16'($urandom_range(128))) - 16'sd64;
         5: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
         6, 7: return $signed(16'($urandom_range(32768))) - 16'sd16384;
         default: return $signed(16'($urandom));
      endcase
   endfunction

   task automatic push_beat(logic signed [15:0] x, y, z, logic has, last);
      contact_beat_type b;
      b.nx = x; b.ny = y; b.nz = z; b.has = has; b.last = last;
      beat_q.push_back(b);
   endtask

   // one update: some contacts, last flag on the final beat
   task automatic push_update(ref int count);
      int nc, kind;
      nc = $urandom_range(0, 4);
      if (nc == 0) begin
         push_beat($signed(16'($urandom)), $signed(16'($urandom)),
                   $signed(16'($urandom)), 1'b0, 1'b1);
         count++;
      end
      for (int i = 0; i < nc; i++) begin
         // an occasional empty beat ahead of a contact beat of the update
         if ($urandom_range(15) == 0)
            push_beat($signed(16'($urandom)), 16'sd0, 16'sd0, 1'b0, 1'b0);
         kind = $urandom_range(7);
         push_beat(rand_comp(kind), rand_comp(kind), rand_comp(kind), 1'b1, i == nc - 1);
         count++;
      end
   endtask

   task automatic apply_setting(int p);
      case (p)
         0: begin
            write_reg(CSR_INVERSE_MASS, 32'd65536);
            write_reg(CSR_FORCE_X, 32'd3 << 16);
            write_reg(CSR_FORCE_Y, -(32'd5 << 16));
            write_reg(CSR_FORCE_Z, 32'd1 << 16);
            write_reg(CSR_RESTITUTION, 32'd29491);
            write_reg(CSR_FRICTION, 32'd29491);
            write_reg(CSR_STOP_THR, 32'd429497);
            write_reg(CSR_SLIP_THR, 32'd43);
         end
         1: begin
            write_reg(CSR_INVERSE_MASS, 32'hffffff);
            write_reg(CSR_FORCE_X, 32'h7fffffff);
            write_reg(CSR_FORCE_Y, 32'h80000000);
            write_reg(CSR_FORCE_Z, rand_force());
            write_reg(CSR_RESTITUTION, 32'd32768);
            write_reg(CSR_FRICTION, 32'd65535);
            write_reg(CSR_STOP_THR, 32'd0);
            write_reg(CSR_SLIP_THR, 32'd0);
         end
         2: begin
            write_reg(CSR_INVERSE_MASS, 32'd0);
            write_reg(CSR_RESTITUTION, 32'd0);
            write_reg(CSR_FRICTION, 32'd0);
            write_reg(CSR_STOP_THR, 32'hffffffff);
            write_reg(CSR_SLIP_THR, 32'hffffffff);
         end
         3: begin
            write_reg(CSR_INVERSE_MASS, 32'd16384);
            write_reg(CSR_FORCE_X, rand_force());
            write_reg(CSR_FORCE_Y, rand_force());
            write_reg(CSR_FORCE_Z, rand_force());
            write_reg(CSR_RESTITUTION, 32'd65535);
            write_reg(CSR_FRICTION, 32'd32768);
            write_reg(CSR_STOP_THR, $urandom);
            write_reg(CSR_SLIP_THR, $urandom_range(4096));
         end
         default: begin
            write_reg(CSR_INVERSE_MASS, $urandom_range(32'hffffff));
            write_reg(CSR_FORCE_X, rand_force());
            write_reg(CSR_FORCE_Y, rand_force());
            write_reg(CSR_FORCE_Z, rand_force());
            write_reg(CSR_RESTITUTION, $urandom_range(65535));
            write_reg(CSR_FRICTION, $urandom_range(65535));
            write_reg(CSR_STOP_THR, $urandom >> $urandom_range(0, 31));
            write_reg(CSR_SLIP_THR, $urandom >> $urandom_range(0, 31));
         end
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (beat_q.size() != 0 || req_valid || velocity_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      int count;
      inv_mass_c = 0;
      force_c = '{0, 0, 0};
      rest_c = RESTITUTION_RST;
      fric_c = FRICTION_RST;
      stop_c = STOP_THR_RST;
      slip_c = SLIP_THR_RST;
      vel_m = '{0, 0, 0};
      sum_m = '{0, 0, 0};
      saw_m = 1'b0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int p = 0; p < PHASES; p++) begin
         if (p < 3) begin
            send_idle = 27; recv_idle = 66;
         end else if (p < 6) begin
            send_idle = 66; recv_idle = 27;
         end else begin
            send_idle = 0; recv_idle = 0;
         end
         apply_setting(p);
         count = 0;
         if (p == 0) begin
            // directed: force-only update, zero and axis normals, extremes
            push_beat(16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1);
            push_beat(16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1);
            push_beat(16'sd16384, 16'sd0, 16'sd0, 1'b1, 1'b1);
            push_beat(16'sd0, -16'sd16384, 16'sd0, 1'b1, 1'b1);
            push_beat(16'sh8000, 16'sh8000, 16'sh8000, 1'b1, 1'b1);
            push_beat(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1, 1'b1);
            push_beat(16'sh7fff, 16'sh8000, 16'sd0, 1'b1, 1'b0);
            push_beat(16'sh5555, 16'shaaaa, 16'sd0, 1'b0, 1'b0);
            push_beat(16'sd0, 16'sd0, 16'sd16384, 1'b1, 1'b0);
            push_beat(16'sd1, -16'sd1, 16'sd1, 1'b1, 1'b1);
            push_beat(16'sd11585, 16'sd11585, 16'sd0, 1'b1, 1'b0);
            push_beat(16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1);
            push_beat(-16'sd16384, 16'sd0, 16'sd0, 1'b1, 1'b1);
            push_beat(16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1);
            count = 14;
         end
         if (p == 6) hold_req = ~hold_req;
         while (count < PHASE_BEATS) push_update(count);
         wait_drained();
      end

      if (mismatches == 0 && velocity_q.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/cvr_pkg.sv
rtl/cvr_div.sv
rtl/contact_velocity_response.sv
tb/sv/tb.sv
